// ===== design/apr_pkg.sv =====
// ----------------------------------------------------------------------------
// apr_pkg
// Shared types and constants for the addressed packet receiver: payload
// structs, frame constants, register indexes and controller/datapath links.
// ----------------------------------------------------------------------------
package apr_pkg;

  // Frame buffer depth and the widths that follow from it.
  localparam int BUF_BYTES = 32;
  localparam int CNT_W     = $clog2(BUF_BYTES + 1);
  localparam int IDX_W     = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;

  // Preamble: a run of zero bytes and then a sync byte.
  localparam int          SYNC_ZEROS = 5;
  localparam int          ZRUN_W     = 3;
  localparam logic [7:0]  SYNC_BYTE  = 8'hFF;

  // Input item kinds.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Register reset values.
  localparam logic [15:0] DEV_ADDR_RST   = 16'h0000;
  localparam logic [15:0] BCAST_ADDR_RST = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RST    = 16'd1000;

  typedef enum logic [1:0] {
    CFG_DEV_ADDR   = 2'd0,
    CFG_BCAST_ADDR = 2'd1,
    CFG_TIMEOUT    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_US    = 2'd0,
    KIND_BCAST = 2'd1,
    KIND_OTHER = 2'd2
  } target_kind_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       is_header;
    logic [7:0] command_code;
    logic [5:0] data_length;
    logic       broadcast;
    logic [7:0] data_byte;
    logic       last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic go_hunt;
    logic clr_idle;
    logic inc_idle;
    logic start_zeros;
    logic inc_zero;
    logic load_addr_hi;
    logic load_addr_lo;
    logic load_cmd;
    logic load_len;
    logic store_data;
    logic load_hdr;
    logic load_data;
  } apr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic byte_zero;
    logic byte_sync;
    logic zeros_done;
    logic timeout_hit;
    logic data_done;
    logic frame_foreign;
    logic count_zero;
    logic emit_last;
    logic out_free;
  } apr_stat_t;

endpackage

// ===== design/apr_ctrl.sv =====
// ----------------------------------------------------------------------------
// apr_ctrl
// Frame parsing and result sequencing state machine.
// ----------------------------------------------------------------------------
module apr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_cmd,
  output logic              in_stall,
  input  apr_pkg::apr_stat_t st,
  output apr_pkg::apr_cmd_t  cmd
);
  import apr_pkg::*;

  typedef enum logic [9:0] {
    S_HUNT      = 10'b00_0000_0001,
    S_ZEROS     = 10'b00_0000_0010,
    S_SYNC      = 10'b00_0000_0100,
    S_ADDR_HI   = 10'b00_0000_1000,
    S_ADDR_LO   = 10'b00_0001_0000,
    S_CMD       = 10'b00_0010_0000,
    S_LEN       = 10'b00_0100_0000,
    S_DATA      = 10'b00_1000_0000,
    S_EMIT_HDR  = 10'b01_0000_0000,
    S_EMIT_DATA = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_fire;

  assign in_stall = state_r inside {S_EMIT_HDR, S_EMIT_DATA};
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_EMIT_HDR: begin
        if (st.out_free) begin
          cmd.load_hdr = 1'b1;
          if (st.count_zero) begin
            cmd.go_hunt = 1'b1;
            state_nxt   = S_HUNT;
          end else begin
            state_nxt = S_EMIT_DATA;
          end
        end
      end
      S_EMIT_DATA: begin
        if (st.out_free) begin
          cmd.load_data = 1'b1;
          if (st.emit_last) begin
            cmd.go_hunt = 1'b1;
            state_nxt   = S_HUNT;
          end
        end
      end
      default: begin
        if (in_fire && in_cmd == CMD_TICK) begin
          // Ticks only count once a frame has started.
          if (state_r != S_HUNT) begin
            if (st.timeout_hit) begin
              cmd.go_hunt = 1'b1;
              state_nxt   = S_HUNT;
            end else begin
              cmd.inc_idle = 1'b1;
            end
          end
        end else if (in_fire) begin
          cmd.clr_idle = 1'b1;
          case (state_r)
            S_HUNT: begin
              if (st.byte_zero) begin
                cmd.start_zeros = 1'b1;
                state_nxt       = S_ZEROS;
              end
            end
            S_ZEROS: begin
              if (!st.byte_zero) begin
                cmd.go_hunt = 1'b1;
                state_nxt   = S_HUNT;
              end else begin
                cmd.inc_zero = 1'b1;
                if (st.zeros_done) begin
                  state_nxt = S_SYNC;
                end
              end
            end
            S_SYNC: begin
              if (st.byte_sync) begin
                state_nxt = S_ADDR_HI;
              end else begin
                cmd.go_hunt = 1'b1;
                state_nxt   = S_HUNT;
              end
            end
            S_ADDR_HI: begin
              cmd.load_addr_hi = 1'b1;
              state_nxt        = S_ADDR_LO;
            end
            S_ADDR_LO: begin
              cmd.load_addr_lo = 1'b1;
              state_nxt        = S_CMD;
            end
            S_CMD: begin
              cmd.load_cmd = 1'b1;
              if (st.byte_zero) begin
                cmd.go_hunt = 1'b1;
                state_nxt   = S_HUNT;
              end else begin
                state_nxt = S_LEN;
              end
            end
            S_LEN: begin
              cmd.load_len = 1'b1;
              if (!st.byte_zero) begin
                state_nxt = S_DATA;
              end else if (st.frame_foreign) begin
                cmd.go_hunt = 1'b1;
                state_nxt   = S_HUNT;
              end else begin
                state_nxt = S_EMIT_HDR;
              end
            end
            S_DATA: begin
              cmd.store_data = 1'b1;
              if (st.data_done) begin
                if (st.frame_foreign) begin
                  cmd.go_hunt = 1'b1;
                  state_nxt   = S_HUNT;
                end else begin
                  state_nxt = S_EMIT_HDR;
                end
              end
            end
            default: begin
              cmd.go_hunt = 1'b1;
              state_nxt   = S_HUNT;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Result emission only ever starts right after a received byte ends a frame.
  a_emit_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_HDR && $past(state_r) != S_EMIT_HDR)
      |-> $past(in_fire && in_cmd == CMD_BYTE))
    else $error("emission started without a frame-ending byte");

  // Ticks never move the parser forward.
  a_tick_no_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_cmd == CMD_TICK) |=> (state_r == $past(state_r) || state_r == S_HUNT))
    else $error("tick advanced the parser");

endmodule

// ===== design/apr_dp.sv =====
// ----------------------------------------------------------------------------
// apr_dp
// Datapath: configuration registers, frame fields, counters, frame buffer
// and the output register.
// ----------------------------------------------------------------------------
module apr_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  apr_pkg::in_item_t  in_data,
  input  logic               out_stall,
  output logic               out_valid,
  output apr_pkg::out_item_t out_data,
  input  apr_pkg::apr_cmd_t  cmd,
  output apr_pkg::apr_stat_t st
);
  import apr_pkg::*;

  logic [15:0]       dev_addr_r, bcast_addr_r, timeout_r;
  logic [7:0]        addr_hi_r;
  target_kind_t      kind_r;
  logic [7:0]        frame_cmd_r;
  logic [CNT_W-1:0]  expected_r, received_r, idx_r, idx_nxt;
  logic [ZRUN_W-1:0] zero_run_r;
  logic [15:0]       idle_r, idle_inc;
  logic [7:0]        mem [BUF_BYTES];
  logic [7:0]        rd_data_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;
  logic [7:0]        b;
  logic [15:0]       addr_full;
  logic [CNT_W-1:0]  len_clamped, rcv_inc, idx_inc;

  assign b           = in_data.rx_byte;
  assign addr_full   = {addr_hi_r, b};
  assign len_clamped = (b > 8'(BUF_BYTES)) ? CNT_W'(BUF_BYTES) : b[CNT_W-1:0];
  assign rcv_inc     = received_r + 1'b1;
  assign idx_inc     = idx_r + 1'b1;
  assign idle_inc    = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;

  assign st.byte_zero     = (b == 8'h00);
  assign st.byte_sync     = (b == SYNC_BYTE);
  assign st.zeros_done    = ((32'(zero_run_r) + 1) >= SYNC_ZEROS);
  assign st.timeout_hit   = (idle_inc > timeout_r);
  assign st.data_done     = (rcv_inc >= expected_r);
  assign st.frame_foreign = (kind_r == KIND_OTHER);
  assign st.count_zero    = (expected_r == '0);
  assign st.emit_last     = (idx_inc == expected_r);
  assign st.out_free      = !out_valid_r || !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r   <= DEV_ADDR_RST;
      bcast_addr_r <= BCAST_ADDR_RST;
      timeout_r    <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEV_ADDR:   dev_addr_r   <= cfg_wdata;
        CFG_BCAST_ADDR: bcast_addr_r <= cfg_wdata;
        CFG_TIMEOUT:    timeout_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Frame fields and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_hi_r   <= '0;
      kind_r      <= KIND_US;
      frame_cmd_r <= '0;
      expected_r  <= '0;
      received_r  <= '0;
      zero_run_r  <= '0;
      idle_r      <= '0;
      idx_r       <= '0;
    end else begin
      if (cmd.go_hunt || cmd.clr_idle) begin
        idle_r <= '0;
      end else if (cmd.inc_idle) begin
        idle_r <= idle_inc;
      end
      if (cmd.go_hunt) begin
        zero_run_r <= '0;
      end else if (cmd.start_zeros) begin
        zero_run_r <= ZRUN_W'(1);
      end else if (cmd.inc_zero) begin
        zero_run_r <= zero_run_r + 1'b1;
      end
      if (cmd.load_addr_hi) begin
        addr_hi_r <= b;
      end
      if (cmd.load_addr_lo) begin
        // Broadcast wins when both addresses match.
        if (addr_full == bcast_addr_r) begin
          kind_r <= KIND_BCAST;
        end else if (addr_full == dev_addr_r) begin
          kind_r <= KIND_US;
        end else begin
          kind_r <= KIND_OTHER;
        end
      end
      if (cmd.load_cmd) begin
        frame_cmd_r <= b;
        expected_r  <= '0;
        received_r  <= '0;
      end
      if (cmd.load_len) begin
        expected_r <= len_clamped;
        received_r <= '0;
      end
      if (cmd.store_data) begin
        received_r <= rcv_inc;
      end
      idx_r <= idx_nxt;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load_cmd) begin
      idx_nxt = '0;
    end else if (cmd.load_data) begin
      idx_nxt = idx_inc;
    end
  end

  // Frame buffer. The read port follows the next emit index so the byte is
  // ready by the time the output register wants it.
  always_ff @(posedge clk) begin
    if (cmd.store_data) begin
      mem[received_r[IDX_W-1:0]] <= b;
    end
    rd_data_r <= mem[idx_nxt[IDX_W-1:0]];
  end

  // Output register.
  always_comb begin
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load_hdr || cmd.load_data) begin
      out_valid_nxt             = 1'b1;
      out_item_nxt.is_header    = cmd.load_hdr;
      out_item_nxt.command_code = frame_cmd_r;
      out_item_nxt.data_length  = 6'(expected_r);
      out_item_nxt.broadcast    = (kind_r == KIND_BCAST);
      out_item_nxt.data_byte    = cmd.load_hdr ? 8'h00 : rd_data_r;
      out_item_nxt.last         = cmd.load_hdr ? st.count_zero : st.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store_data |-> (received_r < expected_r))
    else $error("data byte stored beyond the frame length");

  a_emit_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= expected_r)
    else $error("emit index ran past the frame length");

  a_data_needs_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_data |-> (expected_r != '0 && !cmd.load_hdr))
    else $error("data result emitted for an empty frame");

endmodule

// ===== design/addressed_packet_receiver.sv =====
// ----------------------------------------------------------------------------
// addressed_packet_receiver
// Parses addressed bus frames from received bytes and time ticks and emits
// a header result plus the buffered data bytes of each accepted frame.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall / in_data) carries one byte or one
//   time tick per transfer. While parsing, in_stall stays low and every input
//   transfer is taken.
//   When a byte completes a frame addressed to this node or to the broadcast
//   address with a nonzero command, the block raises in_stall and emits a
//   header result followed by one result per stored data byte, one result per
//   cycle while out_stall is low, into the output register (out_valid /
//   out_stall / out_data). The sequencing state machine and the single
//   output register set this rate, so a frame-ending byte keeps the input
//   stalled while its results are emitted. The first result reaches
//   out_valid through the state register and then the output register.
//   If the receiver stalls, the output register holds its result and the
//   emission waits; input stays stalled until the last result is loaded.
//   A synchronous reset (rst_n low) returns the parser to hunting for the
//   first zero, empties the output register and restores the register reset
//   values. The frame buffer is not cleared. Configuration writes
//   (cfg_we / cfg_index / cfg_wdata) take effect on the next clock edge.
// ----------------------------------------------------------------------------
module addressed_packet_receiver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  apr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output apr_pkg::out_item_t out_data
);
  import apr_pkg::*;

  // Command and status buses between the state machine and the datapath.
  apr_cmd_t  cmd;
  apr_stat_t st;

  // The controller decides what each transfer does; it only sees the item
  // kind, while the byte value reaches it as datapath status.
  apr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the registers, the frame buffer and the output stage.
  apr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
